[hdl/mir_pkg.sv]
// ----------------------------------------------------------------------------
// mir_pkg
// Shared types, constants and the binomial count table for the multi-index
// rank pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package mir_pkg;

  // Fixed geometry of one multi-index
  localparam int NUM_PARTS  = 4;
  localparam int PART_W     = 4;
  localparam int DIM_W      = 2;
  localparam int MODE_W     = 2;
  localparam int RANK_W     = 10;
  localparam int MAX_DEGREE = 15;
  localparam int SUM_W      = 7;   // signed running degree, covers -1 .. 60
  localparam int NUM_CELLS  = NUM_PARTS - 1;

  localparam logic [RANK_W-1:0] MAX_RANK = 10'd815;

  // Ordering codes; the unused code ranks as lex
  localparam logic [MODE_W-1:0] ORDER_LEX        = 2'd0;
  localparam logic [MODE_W-1:0] ORDER_REVLEX     = 2'd1;
  localparam logic [MODE_W-1:0] ORDER_INV_REVLEX = 2'd2;

  // Configuration register indexes
  localparam logic [1:0] REG_ORDER_MODE = 2'd0;
  localparam logic [1:0] REG_DIMENSION  = 2'd1;

  // Dim(w, n) = C(w+n, n) for w = 0..3, n = 0..MAX_DEGREE
  localparam logic [RANK_W-1:0] DIM_TAB [NUM_PARTS][MAX_DEGREE+1] = '{
    '{10'd1, 10'd1, 10'd1, 10'd1, 10'd1, 10'd1, 10'd1, 10'd1,
      10'd1, 10'd1, 10'd1, 10'd1, 10'd1, 10'd1, 10'd1, 10'd1},
    '{10'd1, 10'd2, 10'd3, 10'd4, 10'd5, 10'd6, 10'd7, 10'd8,
      10'd9, 10'd10, 10'd11, 10'd12, 10'd13, 10'd14, 10'd15, 10'd16},
    '{10'd1, 10'd3, 10'd6, 10'd10, 10'd15, 10'd21, 10'd28, 10'd36,
      10'd45, 10'd55, 10'd66, 10'd78, 10'd91, 10'd105, 10'd120, 10'd136},
    '{10'd1, 10'd4, 10'd10, 10'd20, 10'd35, 10'd56, 10'd84, 10'd120,
      10'd165, 10'd220, 10'd286, 10'd364, 10'd455, 10'd560, 10'd680, 10'd816}
  };

  // Item travelling along the chain
  typedef struct packed {
    logic [NUM_PARTS-1:0][PART_W-1:0] parts;
    logic [MODE_W-1:0]                mode;
    logic [DIM_W-1:0]                 dim;
    logic signed [SUM_W-1:0]          s;          // remaining degree minus one
    logic [RANK_W-1:0]                v;          // rank accumulated so far
    logic                             too_large;
  } token_t;

  function automatic logic is_lex(input logic [MODE_W-1:0] mode);
    return (mode != ORDER_REVLEX) && (mode != ORDER_INV_REVLEX);
  endfunction

endpackage

`default_nettype wire

[hdl/mir_front.sv]
// ----------------------------------------------------------------------------
// mir_front
// Entry stage: sums the used parts, flags an oversized degree and seeds the
// running degree and rank for the cell chain.
// ----------------------------------------------------------------------------
`default_nettype none

module mir_front
  import mir_pkg::*;
(
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [NUM_PARTS-1:0][PART_W-1:0] in_parts,
  input  wire logic [MODE_W-1:0]                mode,
  input  wire logic [DIM_W-1:0]                 dim,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output token_t                                out_token
);

  logic [SUM_W-1:0] total;
  token_t           token_next;

  // Degree of the used parts
  always_comb begin
    total = '0;
    for (int i = 0; i < NUM_PARTS; i++) begin
      if (i[DIM_W-1:0] <= dim) begin
        total = total + SUM_W'(in_parts[i]);
      end
    end
  end

  // Seed: lex starts from the top of the degree and counts down; the other orders start at zero
  always_comb begin
    token_next.parts     = in_parts;
    token_next.mode      = mode;
    token_next.dim       = dim;
    token_next.s         = $signed(total) - SUM_W'(1);
    token_next.too_large = (total > SUM_W'(MAX_DEGREE));
    if (is_lex(mode)) begin
      token_next.v = DIM_TAB[dim][total[PART_W-1:0]] - RANK_W'(1);
    end else begin
      token_next.v = '0;
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_token <= token_next;
    end
  end

endmodule

`default_nettype wire

[hdl/mir_cell.sv]
// ----------------------------------------------------------------------------
// mir_cell
// One ranking step: removes one part from the running degree and adds or
// subtracts the matching binomial count, then hands the item on.
// ----------------------------------------------------------------------------
`default_nettype none

module mir_cell
  import mir_pkg::*;
#(
  parameter int STEP = 0
) (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   in_valid,
  output logic        in_ready,
  input  wire token_t in_token,
  output logic        out_valid,
  input  wire logic   out_ready,
  output token_t      out_token
);

  localparam logic [DIM_W-1:0] STEP_IDX = STEP[DIM_W-1:0];

  logic                    active;
  logic [DIM_W-1:0]        weight;
  logic [DIM_W-1:0]        sel;
  logic signed [SUM_W-1:0] s_new;
  logic [RANK_W-1:0]       term;
  token_t                  token_next;

  // Step only exists while it lies below the dimension
  assign active = (STEP_IDX < in_token.dim);
  assign weight = in_token.dim - STEP_IDX;
  assign sel    = (in_token.mode == ORDER_INV_REVLEX) ? weight : STEP_IDX;
  assign s_new  = in_token.s - $signed({{(SUM_W-PART_W){1'b0}}, in_token.parts[sel]});
  assign term   = s_new[SUM_W-1] ? '0 : DIM_TAB[weight][s_new[PART_W-1:0]];

  always_comb begin
    token_next = in_token;
    if (active) begin
      token_next.s = s_new;
      if (is_lex(in_token.mode)) begin
        token_next.v = in_token.v - term;
      end else begin
        token_next.v = in_token.v + term;
      end
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      out_token <= token_next;
    end
  end

endmodule

`default_nettype wire

[hdl/multi_index_rank.sv]
// ----------------------------------------------------------------------------
// multi_index_rank
// Ranks a multi-index among all multi-indices of the same total degree.
// ----------------------------------------------------------------------------
// One transaction in gives one transaction out. The block takes a new
// multi-index every cycle and ranks it in one entry stage that sums the
// parts, then a chain of three cells, one per part boundary, each doing
// one table lookup and one add or subtract. Holding off the output stalls
// the intake and the chain stage by stage, so empty stages still fill up.
// Ordering and dimension are set through the configuration channel, which is
// always ready and should only be written while no transaction is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_index_rank
  import mir_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  // input stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [15:0] s_axis_tdata,   // part_0[3:0], part_1, part_2, part_3
  // output stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [15:0]      m_axis_tdata,   // rank[9:0], zero fill [15:10]
  output logic             m_axis_tuser,   // degree_too_large
  // configuration writes
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [1:0]  cfg_data
);

  logic [MODE_W-1:0] order_mode;
  logic [DIM_W-1:0]  dimension;

  logic              valid [NUM_CELLS+1];
  logic              ready [NUM_CELLS+1];
  token_t            token [NUM_CELLS+1];
  token_t            last_token;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      order_mode <= ORDER_REVLEX;
      dimension  <= 2'd2;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ORDER_MODE: order_mode <= cfg_data;
        REG_DIMENSION:  dimension  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Entry stage
  mir_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_parts  (s_axis_tdata),
    .mode      (order_mode),
    .dim       (dimension),
    .out_valid (valid[0]),
    .out_ready (ready[0]),
    .out_token (token[0])
  );

  // Chain of ranking cells
  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    mir_cell #(.STEP(k)) u_cell (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (valid[k]),
      .in_ready  (ready[k]),
      .in_token  (token[k]),
      .out_valid (valid[k+1]),
      .out_ready (ready[k+1]),
      .out_token (token[k+1])
    );
  end

  // Result from the last cell
  assign last_token         = token[NUM_CELLS];
  assign ready[NUM_CELLS]   = m_axis_tready;
  assign m_axis_tvalid      = valid[NUM_CELLS];
  assign m_axis_tuser       = last_token.too_large;
  assign m_axis_tdata       = {6'b0, last_token.too_large ? RANK_W'(0) : last_token.v};

  // Checks
  a_flag_zero_rank: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 16'd0)
    else $error("flagged result carries a nonzero rank");

  a_rank_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[RANK_W-1:0] <= MAX_RANK)
    else $error("rank beyond the largest degree count");

  a_empty_out_ready: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input held off with an empty output stage");

  a_reset_config: assert property (@(posedge clk)
    $past(rst) |-> order_mode == ORDER_REVLEX && dimension == 2'd2)
    else $error("configuration not at reset values");

endmodule

`default_nettype wire
